>>> hdl/u8d_pkg.sv
package u8d_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 21;
    localparam int unsigned PARTIAL_W = 15;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Byte class boundaries.
    localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] BAD_MIN   = 8'hF8;

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_sequence;
        logic            last;
    } result_t;

    // Results handed from the decoder to the result queue together, up to two.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic                 emit;
        logic [CP_W-1:0]      code_point;
        logic                 bad_sequence;
        logic [1:0]           pending;
        logic [PARTIAL_W-1:0] partial;
    } fresh_t;

    typedef struct packed {
        logic [1:0]           count;
        result_t              r0;
        result_t              r1;
        logic [1:0]           pending;
        logic [PARTIAL_W-1:0] partial;
    } decode_t;

    // Decodes a byte that arrives with no sequence open.
    function automatic fresh_t fresh_byte(logic [BYTE_W-1:0] b);
        fresh_t f;
        f.emit         = 1'b0;
        f.code_point   = REPLACEMENT_CP;
        f.bad_sequence = 1'b0;
        f.pending      = 2'd0;
        f.partial      = '0;
        if (b < CONT_MIN) begin
            f.emit       = 1'b1;
            f.code_point = {13'd0, b};
        end
        else if (b < LEAD2_MIN || b >= BAD_MIN) begin
            f.emit         = 1'b1;
            f.bad_sequence = 1'b1;
        end
        else if (b < LEAD3_MIN) begin
            f.pending = 2'd1;
            f.partial = {10'd0, b[4:0]};
        end
        else if (b < LEAD4_MIN) begin
            f.pending = 2'd2;
            f.partial = {11'd0, b[3:0]};
        end
        else begin
            f.pending = 2'd3;
            f.partial = {12'd0, b[2:0]};
        end
        return f;
    endfunction

    // Full per-byte step: results caused by the byte and the next state.
    function automatic decode_t decode_byte(logic [1:0]           pending,
                                            logic [PARTIAL_W-1:0] partial,
                                            logic [BYTE_W-1:0]    b);
        decode_t         d;
        fresh_t          f;
        logic [CP_W-1:0] v;
        f = fresh_byte(b);
        v = {partial, b[5:0]};
        d.count           = 2'd0;
        d.r0.code_point   = REPLACEMENT_CP;
        d.r0.bad_sequence = 1'b0;
        d.r0.last         = 1'b1;
        d.r1              = d.r0;
        d.pending         = pending;
        d.partial         = partial;
        if (pending != 2'd0) begin
            if (b[7:6] == CONT_TAG) begin
                if (pending == 2'd1) begin
                    d.count         = 2'd1;
                    d.r0.code_point = v;
                    d.pending       = 2'd0;
                    d.partial       = '0;
                end
                else begin
                    d.pending = pending - 2'd1;
                    d.partial = v[PARTIAL_W-1:0];
                end
            end
            else begin
                // Broken sequence: flag it, then treat the byte as fresh.
                d.r0.bad_sequence = 1'b1;
                d.pending         = f.pending;
                d.partial         = f.partial;
                if (f.emit) begin
                    d.count           = 2'd2;
                    d.r0.last         = 1'b0;
                    d.r1.code_point   = f.code_point;
                    d.r1.bad_sequence = f.bad_sequence;
                end
                else begin
                    d.count = 2'd1;
                end
            end
        end
        else begin
            d.pending = f.pending;
            d.partial = f.partial;
            if (f.emit) begin
                d.count           = 2'd1;
                d.r0.code_point   = f.code_point;
                d.r0.bad_sequence = f.bad_sequence;
            end
        end
        return d;
    endfunction

endpackage

>>> hdl/u8d_decode.sv
module u8d_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [u8d_pkg::BYTE_W-1:0]   in_byte,
    input  logic [1:0]                   free_slots,
    output u8d_pkg::push_t               push
);
    import u8d_pkg::*;

    logic                 hold_valid_reg;
    logic [BYTE_W-1:0]    hold_byte_reg;
    logic [1:0]           pending_reg;
    logic [PARTIAL_W-1:0] partial_reg;
    decode_t              dec;
    logic                 fire;

    always_comb
    begin
        dec      = decode_byte(pending_reg, partial_reg, hold_byte_reg);
        // The byte leaves the input register only when all its results fit.
        fire     = hold_valid_reg && (free_slots >= dec.count);
        in_ready = !hold_valid_reg || fire;
        push.count = fire ? dec.count : 2'd0;
        push.r0    = dec.r0;
        push.r1    = dec.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pending_reg    <= 2'd0;
            partial_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                hold_valid_reg <= in_valid;
            end
            if (fire)
            begin
                pending_reg <= dec.pending;
                partial_reg <= dec.partial;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_byte_reg <= in_byte;
        end
    end

endmodule

>>> hdl/u8d_fifo.sv
module u8d_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  u8d_pkg::push_t   push,
    output logic [1:0]       free_slots,
    output logic             out_valid,
    input  logic             out_ready,
    output u8d_pkg::result_t out_data
);
    import u8d_pkg::*;

    localparam logic [1:0] DEPTH = 2'd3;

    result_t    entry_reg [3];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [2:0] count_sum;
    logic       pop;

    function automatic logic [1:0] ptr_inc(logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    always_comb
    begin
        pop        = (count_reg != 2'd0) && out_ready;
        out_valid  = (count_reg != 2'd0);
        out_data   = entry_reg[rd_ptr_reg];
        free_slots = DEPTH - count_reg;
        case (push.count)
            2'd1:    wr_ptr_next = ptr_inc(wr_ptr_reg);
            2'd2:    wr_ptr_next = ptr_inc(ptr_inc(wr_ptr_reg));
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_sum  = {1'b0, count_reg} + {1'b0, push.count} - {2'd0, pop};
        count_next = count_sum[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[ptr_inc(wr_ptr_reg)] <= push.r1;
        end
    end

endmodule

>>> hdl/utf8_stream_decoder.sv
// Channel   Direction  tdata                           tuser          tlast
// s_axis    in         [7:0] raw byte                  -              -
// m_axis    out        [20:0] code point, [23:21] 0    bad_sequence   last result of a byte
//
// One byte is accepted per cycle while the result queue has room for its
// results. Most bytes yield zero or one result; a byte that breaks an open
// sequence and is itself ASCII or an invalid lead yields two, and the second
// is a separate output transaction. A result passes through the input
// register and then the three-entry result queue before it is offered on
// m_axis; while the queue lacks room the byte waits in the input register.
// Reset clears the open sequence and empties both stages. When m_axis stalls
// the queue fills and s_axis_tready drops; it never depends on m_axis_tready
// in the same cycle.
module utf8_stream_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [u8d_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] byte_req
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [u8d_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic                            m_axis_tuser,   // [0] bad_sequence
    output logic                            m_axis_tlast
);
    import u8d_pkg::*;

    push_t      push;
    logic [1:0] free_slots;
    result_t    head;

    // Input register, sequence state and the per-byte decode.
    u8d_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .free_slots (free_slots),
        .push       (push)
    );

    // Result queue; takes up to two results per cycle and drives m_axis.
    u8d_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free_slots (free_slots),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (head)
    );

    assign m_axis_tdata = {{(M_TDATA_W - CP_W){1'b0}}, head.code_point};
    assign m_axis_tuser = head.bad_sequence;
    assign m_axis_tlast = head.last;

endmodule

>>> hdl/u8d_checker.sv
module u8d_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [u8d_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);
    import u8d_pkg::*;

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("m_axis result changed while stalled");

    // An error result always carries the replacement character.
    a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[CP_W-1:0] == REPLACEMENT_CP)
        else $error("error result without U+FFFD");

    // Only the error half of a two-result byte can be non-final.
    a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
        else $error("non-final result that is not an error");

    // The padding above the code point stays zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:CP_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);
